// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, disabled during reset.
`define IPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication on clk, disabled during reset.
`define IPC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipc_pkg
// Types and constants of the frame header classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package ipc_pkg;
	localparam int MaxFrameBytesDefault = 16384;

	localparam logic [3:0] PH_ETH    = 4'd0;
	localparam logic [3:0] PH_V4     = 4'd1;
	localparam logic [3:0] PH_V6     = 4'd2;
	localparam logic [3:0] PH_WALK   = 4'd3;
	localparam logic [3:0] PH_EXTLEN = 4'd4;
	localparam logic [3:0] PH_V6DONE = 4'd5;
	localparam logic [3:0] PH_OTHER  = 4'd6;

	localparam logic [3:0] CL_TCP      = 4'd0;
	localparam logic [3:0] CL_UDP      = 4'd1;
	localparam logic [3:0] CL_OTHER    = 4'd2;
	localparam logic [3:0] CL_NOTIP    = 4'd3;
	localparam logic [3:0] CL_TOOSHORT = 4'd4;
	localparam logic [3:0] CL_SHORTHDR = 4'd5;
	localparam logic [3:0] CL_TOOLONG  = 4'd6;
	localparam logic [3:0] CL_FRAG     = 4'd7;
	localparam logic [3:0] CL_NOPAY    = 4'd8;
	localparam logic [3:0] CL_UNKEXT   = 4'd9;
	localparam logic [3:0] CL_NONE     = 4'd15;
	localparam int         NumClasses  = 10;

	localparam logic [1:0] VER_NONE = 2'd0;
	localparam logic [1:0] VER_V4   = 2'd1;
	localparam logic [1:0] VER_V6   = 2'd2;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	localparam logic [7:0] NH_HOPOPT = 8'd0;
	localparam logic [7:0] NH_TCP    = 8'd6;
	localparam logic [7:0] NH_UDP    = 8'd17;
	localparam logic [7:0] NH_ROUTE  = 8'd43;
	localparam logic [7:0] NH_FRAG   = 8'd44;
	localparam logic [7:0] NH_NONEXT = 8'd59;
	localparam logic [7:0] NH_DSTOPT = 8'd60;

	localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
	localparam logic [15:0] FRAG_MF_MASK     = 16'h2000;

	typedef struct packed {
		logic [3:0]  frame_class;
		logic [1:0]  ip_version;
		logic [7:0]  transport_protocol;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [13:0] transport_offset;
		logic [31:0] class_count;
		logic [31:0] frame_count;
	} result_t;
endpackage
`default_nettype wire

// ----- rtl/ipc_byte_if.sv -----
// ----------------------------------------------------------------------------
// ipc_byte_if
// Byte stream channel carrying frame bytes and the end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none
interface ipc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;
	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/ipc_result_if.sv -----
// ----------------------------------------------------------------------------
// ipc_result_if
// Result channel carrying one classification per frame.
// ----------------------------------------------------------------------------
`default_nettype none
interface ipc_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  frame_class;
	logic [1:0]  ip_version;
	logic [7:0]  transport_protocol;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [13:0] transport_offset;
	logic [31:0] class_count;
	logic [31:0] frame_count;
	modport source (output valid, output frame_class, output ip_version,
		output transport_protocol, output source_port, output dest_port,
		output transport_offset, output class_count, output frame_count, input ready);
	modport sink (input valid, input frame_class, input ip_version,
		input transport_protocol, input source_port, input dest_port,
		input transport_offset, input class_count, input frame_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/ip_frame_header_classifier.sv -----
// ----------------------------------------------------------------------------
// ip_frame_header_classifier
// Parses Ethernet, IPv4/IPv6 and TCP headers byte by byte and classifies
// each frame, keeping saturating per-class and total counters.
// ----------------------------------------------------------------------------
// Channel   Role    Beat
// frames    sink    one frame byte, frame_end on the last byte
// results   source  one classification with counters per frame
//
// A byte is taken every cycle unless the input register is stalled; it is
// held in the input register, then parsed into the header state, and a
// frame's last byte loads the result register, so a result passes the input and result registers in turn.
// A waiting result stalls only a following last byte; other bytes proceed.
// Reset clears all parse state and every counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ip_frame_header_classifier #(
	parameter int MAX_FRAME_BYTES = ipc_pkg::MaxFrameBytesDefault
) (
	input  wire             clk,
	input  wire             arst_n,
	ipc_byte_if.sink        frames,
	ipc_result_if.source    results
);
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HE_RAW = $clog2(MAX_FRAME_BYTES + 2100);
	localparam int HE_W = (HE_RAW > 14) ? HE_RAW : 14;
	localparam int CW = HE_W + 1;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	logic             advance;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [3:0]       phase_q, phase_d;
	logic [3:0]       verdict_q, verdict_d;
	logic [15:0]      ether_q, ether_d;
	logic [3:0]       words_q, words_d;
	logic [15:0]      dlen_q, dlen_d;
	logic [15:0]      frag_q, frag_d;
	logic [7:0]       nh_q, nh_d;
	logic [HE_W-1:0]  he_q, he_d;
	logic [31:0]      ports_q, ports_d;
	logic [31:0]      cnt_q [ipc_pkg::NumClasses];
	logic [31:0]      total_q;

	logic             res_valid_q;
	ipc_pkg::result_t res_q, res_d;
	logic [3:0]       cls;
	logic [CW-1:0]    len_c, he_c, pe_c;
	logic             ports_ok;

	assign advance = valid_s1 && (!end_s1 || !res_valid_q || results.ready);
	assign frames.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			byte_s1 <= frames.data_byte;
			end_s1 <= frames.frame_end;
		end
	end

	function automatic logic [7:0] judge(input logic [7:0] k);
		logic [3:0] ph;
		logic [3:0] vd;
		ph = ipc_pkg::PH_V6DONE;
		if (k == ipc_pkg::NH_HOPOPT || k == ipc_pkg::NH_ROUTE || k == ipc_pkg::NH_DSTOPT) begin
			ph = ipc_pkg::PH_WALK;
			vd = ipc_pkg::CL_NONE;
		end else if (k == ipc_pkg::NH_NONEXT) begin
			vd = ipc_pkg::CL_NOPAY;
		end else if (k == ipc_pkg::NH_FRAG) begin
			vd = ipc_pkg::CL_FRAG;
		end else if (k == ipc_pkg::NH_TCP) begin
			vd = ipc_pkg::CL_TCP;
		end else if (k == ipc_pkg::NH_UDP) begin
			vd = ipc_pkg::CL_UDP;
		end else begin
			vd = ipc_pkg::CL_UNKEXT;
		end
		return {ph, vd};
	endfunction

	always_comb begin
		logic grab;
		pos_d = pos_q;
		phase_d = phase_q;
		verdict_d = verdict_q;
		ether_d = ether_q;
		words_d = words_q;
		dlen_d = dlen_q;
		frag_d = frag_q;
		nh_d = nh_q;
		he_d = he_q;
		ports_d = ports_q;
		pe_c = CW'(pos_q);
		grab = (pe_c >= CW'(he_q)) && (pe_c < CW'(he_q) + CW'(4));
		if (pos_q < MAX_POS) begin
			pos_d = pos_q + POS_W'(1);
			case (phase_q)
				ipc_pkg::PH_ETH: begin
					if (pe_c == CW'(12)) ether_d = {byte_s1, 8'd0};
					if (pe_c == CW'(13)) begin
						ether_d = {ether_q[15:8], byte_s1};
						if (ether_d == ipc_pkg::ETH_IPV4) phase_d = ipc_pkg::PH_V4;
						else if (ether_d == ipc_pkg::ETH_IPV6) phase_d = ipc_pkg::PH_V6;
						else phase_d = ipc_pkg::PH_OTHER;
					end
				end
				ipc_pkg::PH_V4: begin
					if (pe_c == CW'(14)) begin
						words_d = byte_s1[3:0];
						he_d = HE_W'(14) + HE_W'({byte_s1[3:0], 2'b00});
					end else if (pe_c == CW'(16)) dlen_d = {byte_s1, 8'd0};
					else if (pe_c == CW'(17)) dlen_d = {dlen_q[15:8], byte_s1};
					else if (pe_c == CW'(20)) frag_d = {byte_s1, 8'd0};
					else if (pe_c == CW'(21)) frag_d = {frag_q[15:8], byte_s1};
					else if (pe_c == CW'(23)) nh_d = byte_s1;
					if (grab) ports_d = {ports_q[23:0], byte_s1};
				end
				ipc_pkg::PH_V6: begin
					if (pe_c == CW'(20)) nh_d = byte_s1;
					if (pe_c == CW'(53)) begin
						he_d = HE_W'(54);
						{phase_d, verdict_d} = judge(nh_q);
					end
				end
				ipc_pkg::PH_WALK: begin
					if (pe_c == CW'(he_q)) begin
						nh_d = byte_s1;
						phase_d = ipc_pkg::PH_EXTLEN;
					end
				end
				ipc_pkg::PH_EXTLEN: begin
					he_d = he_q + HE_W'({({1'b0, byte_s1} + 9'd1), 3'b000});
					{phase_d, verdict_d} = judge(nh_q);
				end
				ipc_pkg::PH_V6DONE: begin
					if (grab) ports_d = {ports_q[23:0], byte_s1};
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		logic [31:0] cur;
		len_c = CW'(pos_d);
		he_c = CW'(he_d);
		cls = ipc_pkg::CL_NOTIP;
		ports_ok = 1'b0;
		res_d.ip_version = ipc_pkg::VER_NONE;
		res_d.transport_protocol = 8'd0;
		res_d.transport_offset = 14'd0;
		if (len_c < CW'(14)) begin
			cls = ipc_pkg::CL_TOOSHORT;
		end else if (ether_d == ipc_pkg::ETH_IPV4) begin
			res_d.ip_version = ipc_pkg::VER_V4;
			if (len_c < CW'(34)) begin
				cls = ipc_pkg::CL_TOOSHORT;
			end else begin
				res_d.transport_protocol = nh_d;
				res_d.transport_offset = he_d[13:0];
				if (words_d < 4'd5) cls = ipc_pkg::CL_SHORTHDR;
				else if (CW'(dlen_d) > len_c - CW'(14)) cls = ipc_pkg::CL_TOOLONG;
				else if ((frag_d & ipc_pkg::FRAG_OFFSET_MASK) != 16'd0 ||
					(frag_d & ipc_pkg::FRAG_MF_MASK) != 16'd0) cls = ipc_pkg::CL_FRAG;
				else if (nh_d == ipc_pkg::NH_TCP) begin
					if (he_c + CW'(20) > len_c) cls = ipc_pkg::CL_TOOSHORT;
					else begin
						cls = ipc_pkg::CL_TCP;
						ports_ok = 1'b1;
					end
				end else if (nh_d == ipc_pkg::NH_UDP) cls = ipc_pkg::CL_UDP;
				else cls = ipc_pkg::CL_OTHER;
			end
		end else if (ether_d == ipc_pkg::ETH_IPV6) begin
			res_d.ip_version = ipc_pkg::VER_V6;
			if (len_c < CW'(54)) begin
				cls = ipc_pkg::CL_TOOSHORT;
			end else begin
				res_d.transport_protocol = nh_d;
				res_d.transport_offset = he_d[13:0];
				if (phase_d != ipc_pkg::PH_V6DONE || he_c > len_c) cls = ipc_pkg::CL_TOOSHORT;
				else if (verdict_d == ipc_pkg::CL_TCP) begin
					if (he_c + CW'(20) > len_c) cls = ipc_pkg::CL_TOOSHORT;
					else begin
						cls = ipc_pkg::CL_TCP;
						ports_ok = 1'b1;
					end
				end else cls = verdict_d;
			end
		end
		if (cls > ipc_pkg::CL_UNKEXT) cls = ipc_pkg::CL_TOOSHORT;
		cur = cnt_q[cls];
		res_d.frame_class = cls;
		res_d.source_port = ports_ok ? ports_d[31:16] : 16'd0;
		res_d.dest_port = ports_ok ? ports_d[15:0] : 16'd0;
		res_d.class_count = (cur == '1) ? cur : cur + 32'd1;
		res_d.frame_count = (total_q == '1) ? total_q : total_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= ipc_pkg::PH_ETH;
			verdict_q <= ipc_pkg::CL_NONE;
			ether_q <= '0;
			words_q <= '0;
			dlen_q <= '0;
			frag_q <= '0;
			nh_q <= '0;
			he_q <= '0;
			ports_q <= '0;
			total_q <= '0;
			for (int i = 0; i < ipc_pkg::NumClasses; i++) cnt_q[i] <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance && end_s1) res_valid_q <= 1'b1;
			else if (results.ready) res_valid_q <= 1'b0;
			if (advance) begin
				if (end_s1) begin
					pos_q <= '0;
					phase_q <= ipc_pkg::PH_ETH;
					verdict_q <= ipc_pkg::CL_NONE;
					ether_q <= '0;
					words_q <= '0;
					dlen_q <= '0;
					frag_q <= '0;
					nh_q <= '0;
					he_q <= '0;
					ports_q <= '0;
					total_q <= res_d.frame_count;
					cnt_q[cls] <= res_d.class_count;
				end else begin
					pos_q <= pos_d;
					phase_q <= phase_d;
					verdict_q <= verdict_d;
					ether_q <= ether_d;
					words_q <= words_d;
					dlen_q <= dlen_d;
					frag_q <= frag_d;
					nh_q <= nh_d;
					he_q <= he_d;
					ports_q <= ports_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) res_q <= res_d;
	end

	assign results.valid = res_valid_q;
	assign results.frame_class = res_q.frame_class;
	assign results.ip_version = res_q.ip_version;
	assign results.transport_protocol = res_q.transport_protocol;
	assign results.source_port = res_q.source_port;
	assign results.dest_port = res_q.dest_port;
	assign results.transport_offset = res_q.transport_offset;
	assign results.class_count = res_q.class_count;
	assign results.frame_count = res_q.frame_count;

	`IPC_ASSERT_IMP(a_stall_only_when_full, valid_s1 && !advance, res_valid_q && !results.ready)
	`IPC_ASSERT_NXT(a_frame_restart, advance && end_s1, pos_q == '0 && phase_q == ipc_pkg::PH_ETH)
	`IPC_ASSERT_NXT(a_total_bumps, advance && end_s1 && total_q != '1, total_q == $past(total_q) + 32'd1 && res_valid_q)
endmodule
`default_nettype wire
